[hw/rtl/addressable_led_frame_serializer_macros.svh]
// Assertion macros used by the checker file of the LED frame serializer.
// Depends on nothing; include by bare file name.
`ifndef ADDRESSABLE_LED_FRAME_SERIALIZER_MACROS_SVH
`define ADDRESSABLE_LED_FRAME_SERIALIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ALFS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ALFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/alfs_pkg.sv]
// Shared types and constants of the addressable LED frame serializer.
// Used by the channel interfaces and the top level.
package alfs_pkg;

    localparam int MAX_LEDS_DEF     = 256;
    localparam int BITS_PER_LED_DEF = 24;

    localparam int OPCODE_W    = 2;
    localparam int INDEX_W     = 8;
    localparam int LED_COUNT_W = 9;
    localparam int COLOR_W     = 24;
    localparam int TICK_W      = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // Highest bit of a stored color word; sent first.
    localparam int COLOR_MSB = 23;

    localparam logic [LED_COUNT_W-1:0] LED_COUNT_RST   = 9'd0;
    localparam logic [TICK_W-1:0]      SHORT_TICKS_RST = 16'd8;
    localparam logic [TICK_W-1:0]      LONG_TICKS_RST  = 16'd16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_FILL  = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LED_COUNT   = 2'd0,
        CFG_SHORT_TICKS = 2'd1,
        CFG_LONG_TICKS  = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
    } t_result;

endpackage

[hw/rtl/alfs_channels.sv]
// Valid/ready channel interfaces of the LED frame serializer:
// command items, result items and configuration writes. Depends on alfs_pkg.
interface alfs_item_if;
    logic                               valid;
    logic                               ready;
    logic [alfs_pkg::OPCODE_W-1:0]      opcode;
    logic [alfs_pkg::INDEX_W-1:0]       first_index;
    logic [alfs_pkg::LED_COUNT_W-1:0]   fill_count;
    logic [alfs_pkg::COLOR_W-1:0]       color;

    modport source (output valid, output opcode, output first_index, output fill_count,
                    output color, input ready);
    modport sink   (input valid, input opcode, input first_index, input fill_count,
                    input color, output ready);
endinterface

interface alfs_result_if;
    logic valid;
    logic ready;
    logic pin_level;
    logic busy_res;

    modport source (output valid, output pin_level, output busy_res, input ready);
    modport sink   (input valid, input pin_level, input busy_res, output ready);
endinterface

interface alfs_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [alfs_pkg::CFG_INDEX_W-1:0]   index;
    logic [alfs_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/addressable_led_frame_serializer.sv]
// Top level of the addressable LED frame serializer: pixel memory, fill
// sequencer, pulse timer and result queue. Depends on alfs_pkg, alfs_channels.
//
// Usage:
//   i_cfg    - register writes (0 led_count, 1 short_ticks, 2 long_ticks);
//              always ready, take effect at the accepting edge.
//   i_item   - one command per transaction: fill a range, start a frame, or
//              one time tick. Every command returns exactly one result.
//   o_result - pin_level and busy_res as they stand after the command.
// Results are registered: a result is valid the cycle after its command is accepted.
// Start, tick and no-op commands leave i_item.ready high, so ticks can arrive
//   every cycle while the result queue has room. A fill writes the first entry
//   at acceptance, then holds i_item.ready low, one write per remaining entry.
// The pixel memory has one write and one read port; the read port tracks the
//   LED being sent and holds entry 0 while idle, with write forwarding.
// Reset: registers return to defaults; pixel contents are left as they are
//   and must be written before a frame sends them. No clearing pass.
// Stall: a two-entry result queue absorbs one extra command while o_result
//   is stalled; with both entries full, i_item.ready drops.
module addressable_led_frame_serializer #(
    parameter int MAX_LEDS     = alfs_pkg::MAX_LEDS_DEF,
    parameter int BITS_PER_LED = alfs_pkg::BITS_PER_LED_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    alfs_cfg_if.sink       i_cfg,
    alfs_item_if.sink      i_item,
    alfs_result_if.source  o_result
);
    import alfs_pkg::*;

    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int BW = $clog2(BITS_PER_LED);
    localparam int NW = ($clog2(MAX_LEDS + 1) > LED_COUNT_W) ? $clog2(MAX_LEDS + 1)
                                                              : LED_COUNT_W;

    typedef enum logic {
        ST_READY,
        ST_FILL
    } t_state;

    // Configuration
    logic [LED_COUNT_W-1:0] r_led_count;
    logic [TICK_W-1:0]      r_short;
    logic [TICK_W-1:0]      r_long;

    // Frame state
    t_state                 r_state,   n_state;
    logic [TICK_W-1:0]      r_tick,    n_tick;
    logic [TICK_W-1:0]      r_match,   n_match;
    logic                   r_high,    n_high;
    logic [BW-1:0]          r_bit,     n_bit;
    logic [AW-1:0]          r_led,     n_led;
    logic                   r_sending, n_sending;
    logic                   r_line,    n_line;

    // Fill sequencer
    logic [NW-1:0]          r_cur,   n_cur;
    logic [NW-1:0]          r_end,   n_end;
    logic [COLOR_W-1:0]     r_color, n_color;

    // Pixel memory
    logic [COLOR_W-1:0]     r_mem [MAX_LEDS];
    logic [COLOR_W-1:0]     r_rd;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [COLOR_W-1:0]     mem_wdata;
    logic [AW-1:0]          mem_raddr;

    // Result queue
    t_result                r_q [2];
    logic                   r_wp;
    logic                   r_rp;
    logic [1:0]             r_cnt;

    logic                   in_accept;
    logic                   out_pop;
    logic                   cfg_accept;
    logic [NW-1:0]          active;
    logic [NW-1:0]          first_n;
    logic [NW:0]            fill_sum;
    logic [NW-1:0]          fill_end;
    logic [TICK_W-1:0]      tick_inc;
    logic                   cur_bit;
    t_result                res;

    function automatic logic f_data_bit(logic [COLOR_W-1:0] word, logic [BW-1:0] bitp);
        logic [BW-1:0] pos;
        pos = BW'(BITS_PER_LED - 1) - bitp;
        // Positions above the color word read as zero on wide LED words.
        f_data_bit = (pos <= BW'(COLOR_MSB)) ? word[pos[4:0]] : 1'b0;
    endfunction

    assign active = (NW'(r_led_count) > NW'(MAX_LEDS)) ? NW'(MAX_LEDS) : NW'(r_led_count);

    assign in_accept  = i_item.valid && i_item.ready;
    assign out_pop    = o_result.valid && o_result.ready;
    assign cfg_accept = i_cfg.valid && i_cfg.ready;

    assign i_item.ready = (r_state == ST_READY) && (r_cnt != 2'd2);
    assign i_cfg.ready  = 1'b1;

    assign o_result.valid     = (r_cnt != 2'd0);
    assign o_result.pin_level = r_q[r_rp].pin_level;
    assign o_result.busy_res  = r_q[r_rp].busy_res;

    assign first_n  = NW'(i_item.first_index);
    assign fill_sum = (NW + 1)'(first_n) + (NW + 1)'(i_item.fill_count);
    assign fill_end = (i_item.fill_count == '0)             ? active :
                      (fill_sum > (NW + 1)'(active))        ? active : NW'(fill_sum);
    assign tick_inc = r_tick + TICK_W'(1);
    assign cur_bit  = f_data_bit(r_rd, r_bit);

    always_comb begin
        n_state   = r_state;
        n_tick    = r_tick;
        n_match   = r_match;
        n_high    = r_high;
        n_bit     = r_bit;
        n_led     = r_led;
        n_sending = r_sending;
        n_line    = r_line;
        n_cur     = r_cur;
        n_end     = r_end;
        n_color   = r_color;
        mem_we    = 1'b0;
        mem_waddr = AW'(r_cur);
        mem_wdata = r_color;

        unique case (r_state)
            ST_READY: begin
                if (in_accept) begin
                    unique case (t_opcode'(i_item.opcode))
                        OP_FILL: begin
                            if (!r_sending && (first_n < active)) begin
                                // Write the first entry now, sweep the rest.
                                mem_we    = 1'b1;
                                mem_waddr = AW'(first_n);
                                mem_wdata = i_item.color;
                                n_cur     = first_n + NW'(1);
                                n_end     = fill_end;
                                n_color   = i_item.color;
                                if ((first_n + NW'(1)) < fill_end) begin
                                    n_state = ST_FILL;
                                end
                            end
                        end
                        OP_START: begin
                            if (!r_sending && (active != '0)) begin
                                // Read port holds entry 0 while idle.
                                n_match   = f_data_bit(r_rd, '0) ? r_long : r_short;
                                n_tick    = '0;
                                n_high    = 1'b1;
                                n_bit     = '0;
                                n_led     = '0;
                                n_line    = 1'b1;
                                n_sending = 1'b1;
                            end
                        end
                        OP_TICK: begin
                            if (r_sending) begin
                                if (tick_inc < r_match) begin
                                    n_tick = tick_inc;
                                end else begin
                                    n_tick = '0;
                                    n_line = ~r_line;
                                    if (r_high) begin
                                        n_match = cur_bit ? r_short : r_long;
                                        n_high  = 1'b0;
                                        if (((BW + 1)'(r_bit) + (BW + 1)'(1))
                                                < (BW + 1)'(BITS_PER_LED)) begin
                                            n_bit = r_bit + BW'(1);
                                        end else begin
                                            n_bit = '0;
                                            if ((NW'(r_led) + NW'(1)) < active) begin
                                                n_led = r_led + AW'(1);
                                            end else begin
                                                n_sending = 1'b0;
                                                n_line    = 1'b0;
                                                n_high    = 1'b1;
                                            end
                                        end
                                    end else begin
                                        n_match = cur_bit ? r_long : r_short;
                                        n_high  = 1'b1;
                                    end
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FILL: begin
                mem_we = 1'b1;
                n_cur  = r_cur + NW'(1);
                if ((r_cur + NW'(1)) >= r_end) begin
                    n_state = ST_READY;
                end
            end
            default: begin
                n_state = ST_READY;
            end
        endcase
    end

    // Follow the LED being sent; park on entry 0 while idle.
    assign mem_raddr = n_sending ? n_led : '0;

    assign res.pin_level = n_line;
    assign res.busy_res  = n_sending;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count <= LED_COUNT_RST;
            r_short     <= SHORT_TICKS_RST;
            r_long      <= LONG_TICKS_RST;
            r_state     <= ST_READY;
            r_tick      <= '0;
            r_match     <= '0;
            r_high      <= 1'b1;
            r_bit       <= '0;
            r_led       <= '0;
            r_sending   <= 1'b0;
            r_line      <= 1'b0;
            r_wp        <= 1'b0;
            r_rp        <= 1'b0;
            r_cnt       <= 2'd0;
        end else begin
            if (cfg_accept) begin
                unique case (t_cfg_index'(i_cfg.index))
                    CFG_LED_COUNT:   r_led_count <= i_cfg.data[LED_COUNT_W-1:0];
                    CFG_SHORT_TICKS: r_short     <= i_cfg.data[TICK_W-1:0];
                    CFG_LONG_TICKS:  r_long      <= i_cfg.data[TICK_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_state   <= n_state;
            r_tick    <= n_tick;
            r_match   <= n_match;
            r_high    <= n_high;
            r_bit     <= n_bit;
            r_led     <= n_led;
            r_sending <= n_sending;
            r_line    <= n_line;
            if (in_accept) begin
                r_wp <= ~r_wp;
            end
            if (out_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, in_accept} - {1'b0, out_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_end   <= n_end;
        r_color <= n_color;
        if (in_accept) begin
            r_q[r_wp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        // Forward a write to the entry being read.
        if (mem_we && (mem_waddr == mem_raddr)) begin
            r_rd <= mem_wdata;
        end else begin
            r_rd <= r_mem[mem_raddr];
        end
    end

endmodule

[hw/rtl/alfs_checker.sv]
// Port-level checker for the LED frame serializer, bound to the top level.
// Depends on addressable_led_frame_serializer_macros.svh.
`include "addressable_led_frame_serializer_macros.svh"

module alfs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_pin_level,
    input logic i_busy_res
);

    // Every accepted command leaves a result waiting in the next cycle.
    `ALFS_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, i_in_valid && i_in_ready, i_out_valid, "accepted transaction produced no result")

    // A result that shows no frame being sent shows the data line low.
    `ALFS_ASSERT_IMPL(a_idle_line_low, i_clk, i_rst_n, i_out_valid && !i_busy_res, !i_pin_level, "data line high while idle")

    // Hold a stalled result.
    `ALFS_ASSERT_NEXT(a_result_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_pin_level) && $stable(i_busy_res), "stalled result changed")

endmodule

bind addressable_led_frame_serializer alfs_checker u_alfs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_pin_level (o_result.pin_level),
    .i_busy_res  (o_result.busy_res)
);
